// ----- rtl/fomm_pkg.sv -----
package fomm_pkg;

  // Payload types
  typedef struct packed {
    logic signed [15:0] strafe_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] rotate_cmd;
    logic signed [31:0] heading;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] left_front;
    logic signed [15:0] left_rear;
    logic signed [15:0] right_front;
    logic signed [15:0] right_rear;
  } out_res_t;

  // Default and limit of the rotation stage count
  localparam int CordicStagesDef = 16;
  localparam int TableLen        = 24;

  // Datapath widths
  localparam int CW     = 34;  // rotation x and y
  localparam int ZW     = 33;  // residual angle
  localparam int WW     = 20;  // wheel sums
  localparam int QB     = 20;  // quotient bits of the scaling divide
  localparam int DenW   = 35;  // divisor, magnitude of the largest wheel sum times 2^15
  localparam int RemW   = 55;  // partial remainder
  localparam int SqrtW  = 64;  // root extraction word
  localparam int SqrtN  = 32;  // root digits

  // Heading wrap constants: a full turn is 45 * 2^19 units
  localparam int HdgDiv       = 45;
  localparam int HdgOff       = 4140;      // 92 turns of the upper part
  localparam int RecipHi      = 11651;     // ceil(2^19 / 45)
  localparam int RecipHiShift = 19;
  localparam longint RecipW   = 47721859;  // ceil(2^31 / 45)

  localparam longint GainQ30 = 652032874;
  localparam int     OneQ15  = 32768;

  // Angle table in units of 2^-32 turn
  localparam logic [0:TableLen-1][31:0] AtanTurns = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Fraction of the phase for each remainder of the divide by 45
  typedef logic [0:HdgDiv-1][12:0] frac_tbl_t;

  function automatic frac_tbl_t build_frac_tbl();
    frac_tbl_t t;
    for (int i = 0; i < HdgDiv; i++) begin
      t[i] = 13'((i * 8192) / HdgDiv);
    end
    return t;
  endfunction

  localparam frac_tbl_t FracTbl = build_frac_tbl();

  // Stage payloads
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [15:0]   rot;
  } cordic_t;

  typedef struct packed {
    logic [SqrtW-1:0]      n;
    logic [SqrtW-1:0]      root;
    logic [3:0][WW-1:0]    wheel;
    logic [WW-1:0]         amax;
  } sqrt_t;

  typedef struct packed {
    logic [RemW-1:0]      rem;
    logic [DenW-1:0]      den;
    logic [QB-1:0]        quo;
    logic                 neg;
    logic                 scale;
    logic signed [WW-1:0] wheel;
  } div_t;

  // Clamp to the Q1.15 range
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/field_oriented_mecanum_mixer_unit.sv -----
// Field-oriented mecanum mixer. Each request carries strafe, forward and
// rotation commands in Q1.15 and a gyro heading in 1/65536 degree; the block
// returns the four wheel drives in Q1.15. The datapath is a single pipeline of
// cells that all advance together: four heading-wrap stages, CORDIC_STAGES
// rotation cells, four gain and mixing stages, 32 square-root cells, one
// multiply stage, 20 divider cells per wheel and the output register. A new
// request is taken every cycle; the pipeline stalls only while the output
// register holds a result that has not been taken.
module field_oriented_mecanum_mixer_unit #(
  parameter int CORDIC_STAGES = fomm_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fomm_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fomm_pkg::out_res_t out_data
);
  import fomm_pkg::*;

  logic adv;

  logic    v0_r, v1_r, v2_r, v3_r;
  in_req_t in_r;
  logic [24:0] w1_r, w2_r;
  logic [19:0] a2_r;
  logic [31:0] phase3_r;
  logic signed [15:0] sx1_r, fy1_r, rot1_r, sx2_r, fy2_r, rot2_r, sx3_r, fy3_r, rot3_r;

  logic gv1_r, gv2_r, gv3_r, gv4_r, mv_r, out_valid_r;
  logic signed [31:0] px_r, py_r;
  logic signed [15:0] rg1_r, rg2_r;
  logic signed [17:0] xq_r, yq_r;
  logic [3:0][WW-1:0] wh3_r;
  logic signed [35:0] xx_r, yy_r;
  sqrt_t   sq4_r;
  div_t [3:0] dv_r;
  out_res_t out_r;

  // Valid and data taps of the cell chains.
  logic    cv [CORDIC_STAGES+1];
  cordic_t cd [CORDIC_STAGES+1];
  logic    sv [SqrtN+1];
  sqrt_t   sd [SqrtN+1];
  logic    dvv [QB+1];

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Valid bits of the stages kept here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      gv1_r <= 1'b0; gv2_r <= 1'b0; gv3_r <= 1'b0; gv4_r <= 1'b0;
      mv_r <= 1'b0; out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid; v1_r <= v0_r; v2_r <= v1_r; v3_r <= v2_r;
      gv1_r <= cv[CORDIC_STAGES]; gv2_r <= gv1_r; gv3_r <= gv2_r; gv4_r <= gv3_r;
      mv_r <= sv[SqrtN];
      out_valid_r <= dvv[QB];
    end
  end

  // Heading wrap: upper part modulo 45, then phase = w * 2^13 / 45.
  logic [13:0] hi_off;
  logic [27:0] hi_prod;
  logic [7:0]  hi_q;
  logic [5:0]  hi_r;
  logic [50:0] w_prod;
  logic [5:0]  frac_idx;

  always_comb begin
    hi_off   = 14'(int'($signed(in_r.heading[31:19])) + HdgOff);
    hi_prod  = 28'(hi_off) * 28'(RecipHi);
    hi_q     = hi_prod[RecipHiShift +: 8];
    hi_r     = 6'(hi_off - 14'(hi_q) * 14'(HdgDiv));
    w_prod   = 51'(w1_r) * 51'(RecipW);
    frac_idx = 6'(w2_r - 25'(a2_r) * 25'(HdgDiv));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r     <= in_data;
      w1_r     <= {hi_r[5:0], in_r.heading[18:0]};
      sx1_r    <= in_r.strafe_x; fy1_r <= in_r.forward_y; rot1_r <= in_r.rotate_cmd;
      w2_r     <= w1_r;
      a2_r     <= w_prod[50:31];
      sx2_r    <= sx1_r; fy2_r <= fy1_r; rot2_r <= rot1_r;
      phase3_r <= {a2_r[18:0], 13'b0} + 32'(FracTbl[frac_idx]);
      sx3_r    <= sx2_r; fy3_r <= fy2_r; rot3_r <= rot2_r;
    end
  end

  // Whole quarter turns are applied exactly before the CORDIC chain.
  cordic_t c0;
  logic signed [CW-1:0] xs, ys;

  always_comb begin
    xs = CW'(sx3_r) <<< 14;
    ys = CW'(fy3_r) <<< 14;
    c0.rot = rot3_r;
    c0.z   = ZW'({2'b00, phase3_r[29:0]});
    case (phase3_r[31:30])
      2'd1:    begin c0.x = -ys; c0.y = xs;  end
      2'd2:    begin c0.x = -xs; c0.y = -ys; end
      2'd3:    begin c0.x = ys;  c0.y = -xs; end
      default: begin c0.x = xs;  c0.y = ys;  end
    endcase
  end

  assign cv[0] = v3_r;
  assign cd[0] = c0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    fomm_cordic_cell #(.SHIFT(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(cv[i]), .d_i(cd[i]), .vld_o(cv[i+1]), .d_o(cd[i+1])
    );
  end

  // Gain removal, rounding, wheel sums and squares.
  logic signed [64:0] gx, gy;
  logic signed [31:0] xr, yr;
  logic signed [WW-1:0] xw, yw, rw;
  logic signed [WW-1:0] mx;
  logic [WW-1:0] amax;

  always_comb begin
    gx = 65'(cd[CORDIC_STAGES].x) * 65'(GainQ30);
    gy = 65'(cd[CORDIC_STAGES].y) * 65'(GainQ30);
    xr = px_r + 32'sd8192;
    yr = py_r + 32'sd8192;
    xw = WW'(xq_r);
    yw = WW'(yq_r);
    rw = WW'(rg2_r);
    mx = $signed(wh3_r[0]);
    for (int k = 1; k < 4; k++) begin
      if ($signed(wh3_r[k]) > mx) begin
        mx = $signed(wh3_r[k]);
      end
    end
    amax = mx[WW-1] ? WW'(-mx) : WW'(mx);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r  <= gx[61:30];
      py_r  <= gy[61:30];
      rg1_r <= cd[CORDIC_STAGES].rot;
      xq_r  <= xr[31:14];
      yq_r  <= yr[31:14];
      rg2_r <= rg1_r;
      wh3_r[0] <= yw + rw + xw;
      wh3_r[1] <= yw + rw - xw;
      wh3_r[2] <= -yw + rw + xw;
      wh3_r[3] <= -yw + rw - xw;
      xx_r  <= 36'(xq_r) * 36'(xq_r);
      yy_r  <= 36'(yq_r) * 36'(yq_r);
      sq4_r.n     <= SqrtW'(37'(xx_r) + 37'(yy_r)) << 29;
      sq4_r.root  <= '0;
      sq4_r.wheel <= wh3_r;
      sq4_r.amax  <= amax;
    end
  end

  // Magnitude over root two by bitwise square root.
  assign sv[0] = gv4_r;
  assign sd[0] = sq4_r;

  for (genvar i = 0; i < SqrtN; i++) begin : g_sqrt
    fomm_sqrt_cell #(.BIT_POS(62 - 2 * i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .vld_i(sv[i]), .d_i(sd[i]), .vld_o(sv[i+1]), .d_o(sd[i+1])
    );
  end

  // Numerators of the four scaling divides.
  logic [31:0] smag;
  logic [WW-1:0] absv [4];
  logic [51:0] mprod [4];

  always_comb begin
    smag = sd[SqrtN].root[31:0];
    for (int k = 0; k < 4; k++) begin
      absv[k]  = sd[SqrtN].wheel[k][WW-1] ? WW'(-$signed(sd[SqrtN].wheel[k]))
                                          : sd[SqrtN].wheel[k];
      mprod[k] = 52'(absv[k]) * 52'(smag);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        dv_r[k].rem   <= RemW'(mprod[k]) + (RemW'(sd[SqrtN].amax) << 14);
        dv_r[k].den   <= DenW'(sd[SqrtN].amax) << 15;
        dv_r[k].quo   <= '0;
        dv_r[k].neg   <= sd[SqrtN].wheel[k][WW-1];
        dv_r[k].scale <= sd[SqrtN].amax > WW'(OneQ15);
        dv_r[k].wheel <= $signed(sd[SqrtN].wheel[k]);
      end
    end
  end

  // Four divider lanes in step; lane 0 carries the valid bit.
  div_t dd [4][QB+1];
  logic dvx [4][QB+1];
  assign dvv[0] = mv_r;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign dd[l][0]  = dv_r[l];
    assign dvx[l][0] = mv_r;
    for (genvar j = 0; j < QB; j++) begin : g_bit
      fomm_div_cell #(.POS(QB - 1 - j)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .vld_i(dvx[l][j]), .d_i(dd[l][j]), .vld_o(dvx[l][j+1]), .d_o(dd[l][j+1])
      );
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_vld
    assign dvv[j] = dvx[0][j];
  end

  // Sign, selection and saturation.
  logic signed [15:0] res [4];
  logic signed [21:0] rs;

  always_comb begin
    rs = '0;
    for (int k = 0; k < 4; k++) begin
      rs = $signed({2'b00, dd[k][QB].quo});
      if (dd[k][QB].neg) begin
        rs = -rs;
      end
      res[k] = dd[k][QB].scale ? sat16(rs) : sat16(22'(dd[k][QB].wheel));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.left_front  <= res[0];
      out_r.left_rear   <= res[1];
      out_r.right_front <= res[2];
      out_r.right_rear  <= res[3];
    end
  end

endmodule

// ----- rtl/fomm_cordic_cell.sv -----
module fomm_cordic_cell #(
  parameter int SHIFT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  fomm_pkg::cordic_t d_i,
  output logic              vld_o,
  output fomm_pkg::cordic_t d_o
);
  import fomm_pkg::*;

  logic              vld_r;
  cordic_t           d_r;
  cordic_t           d_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] at;

  // One micro-rotation toward zero residual angle.
  always_comb begin
    dx = d_i.y >>> SHIFT;
    dy = d_i.x >>> SHIFT;
    at = ZW'(AtanTurns[SHIFT]);
    d_nxt = d_i;
    if (!d_i.z[ZW-1]) begin
      d_nxt.x = d_i.x - dx;
      d_nxt.y = d_i.y + dy;
      d_nxt.z = d_i.z - at;
    end else begin
      d_nxt.x = d_i.x + dx;
      d_nxt.y = d_i.y - dy;
      d_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ----- rtl/fomm_sqrt_cell.sv -----
module fomm_sqrt_cell #(
  parameter int BIT_POS = 62
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  fomm_pkg::sqrt_t d_i,
  output logic            vld_o,
  output fomm_pkg::sqrt_t d_o
);
  import fomm_pkg::*;

  localparam logic [SqrtW-1:0] Bit = SqrtW'(1) << BIT_POS;

  logic             vld_r;
  sqrt_t            d_r;
  sqrt_t            d_nxt;
  logic [SqrtW-1:0] trial;

  // One digit of the bitwise square root.
  always_comb begin
    trial = d_i.root + Bit;
    d_nxt = d_i;
    if (d_i.n >= trial) begin
      d_nxt.n    = d_i.n - trial;
      d_nxt.root = (d_i.root >> 1) + Bit;
    end else begin
      d_nxt.root = d_i.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

// ----- rtl/fomm_div_cell.sv -----
module fomm_div_cell #(
  parameter int POS = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           vld_i,
  input  fomm_pkg::div_t d_i,
  output logic           vld_o,
  output fomm_pkg::div_t d_o
);
  import fomm_pkg::*;

  logic            vld_r;
  div_t            d_r;
  div_t            d_nxt;
  logic [RemW-1:0] dsh;

  // One restoring quotient bit.
  always_comb begin
    dsh   = RemW'(d_i.den) << POS;
    d_nxt = d_i;
    if (d_i.rem >= dsh) begin
      d_nxt.rem      = d_i.rem - dsh;
      d_nxt.quo[POS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule
